// File: sv/vcsc_pkg.sv
package vcsc_pkg;

    // input word: mode selects the encode or decode path
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // prefix bytes and range limits of the compact size format
    localparam logic [7:0]  PFX_16 = 8'hFD;
    localparam logic [7:0]  PFX_32 = 8'hFE;
    localparam logic [7:0]  PFX_64 = 8'hFF;
    localparam logic [63:0] MAX_16 = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] MAX_32 = 64'h0000_0000_FFFF_FFFF;

    // total encoding lengths, prefix included
    localparam logic [3:0] LEN_1 = 4'd1;
    localparam logic [3:0] LEN_3 = 4'd3;
    localparam logic [3:0] LEN_5 = 4'd5;
    localparam logic [3:0] LEN_9 = 4'd9;

    // payload bytes that follow each prefix
    localparam logic [3:0] PAY_16 = 4'd2;
    localparam logic [3:0] PAY_32 = 4'd4;
    localparam logic [3:0] PAY_64 = 4'd8;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SMALL = 2'd1,
        STAT_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [63:0] value_in;
        logic [3:0]  space_left;
        logic [7:0]  in_byte;
        logic        buffer_end;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [63:0] value_out;
        logic [3:0]  byte_count;
        t_status     status;
        logic        last;
    } t_out_word;

endpackage

// File: sv/vcsc_in_if.sv
interface vcsc_in_if
    import vcsc_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/vcsc_out_if.sv
interface vcsc_out_if
    import vcsc_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/varint_compact_size_codec_unit.sv
// channel   dir  word        handshake
// i_item    in   t_in_word   valid/ready, taken when both high
// o_res     out  t_out_word  valid/ready, taken when both high
//
// each input word sits in one item register, results leave through one result register
// decode word: zero or one result
// encode word: one emitted byte (1, 3, 5 or 9 in all) per cycle while the result register is free,
//   set by the byte index counter stepping through the item register; an error gives a single result
// a new word is taken in the cycle the current one finishes, so words run back to back
// synchronous active-low reset clears the valid flags, the byte index and the decoder state
// a stalled result register holds the item stage; a word that yields no result never waits
module varint_compact_size_codec_unit
    import vcsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    vcsc_in_if.sink          i_item,
    vcsc_out_if.source       o_res
);

    // item stage
    t_in_word  r_item;
    logic      r_item_vld;
    logic [3:0] r_idx;
    logic [3:0] n_idx;

    // decoder state
    logic [3:0]  r_expected;
    logic [3:0]  r_seen;
    logic [63:0] r_acc;
    logic [3:0]  n_expected;
    logic [3:0]  n_seen;
    logic [63:0] n_acc;

    // result register
    t_out_word r_res;
    logic      r_res_vld;

    // encode path
    logic [3:0] enc_total;
    logic [7:0] enc_prefix;
    logic       enc_fits;
    logic [3:0] idx_m1;
    logic [7:0] enc_byte;
    logic       enc_last;
    t_out_word  enc_res;

    // decode path
    logic        dec_has_res;
    t_out_word   dec_res;
    logic [3:0]  seen_inc;
    logic [63:0] acc_merged;

    // stage control
    logic      has_res;
    t_out_word res;
    logic      out_free;
    logic      step;
    logic      item_done;

    // size class, prefix and one output byte per step
    always_comb begin
        if (r_item.value_in < {56'd0, PFX_16}) begin
            enc_total  = LEN_1;
            enc_prefix = r_item.value_in[7:0];
        end else if (r_item.value_in <= MAX_16) begin
            enc_total  = LEN_3;
            enc_prefix = PFX_16;
        end else if (r_item.value_in <= MAX_32) begin
            enc_total  = LEN_5;
            enc_prefix = PFX_32;
        end else begin
            enc_total  = LEN_9;
            enc_prefix = PFX_64;
        end
        enc_fits = (r_item.space_left >= enc_total);
        idx_m1   = r_idx - 4'd1;
        enc_byte = 8'(r_item.value_in >> {idx_m1[2:0], 3'b000});
        enc_last = ((r_idx + 4'd1) == enc_total);

        enc_res = '0;
        if (!enc_fits) begin
            enc_res.kind   = KIND_ERROR;
            enc_res.status = STAT_SMALL;
            enc_res.last   = 1'b1;
        end else begin
            enc_res.kind       = KIND_BYTE;
            enc_res.out_byte   = (r_idx == 4'd0) ? enc_prefix : enc_byte;
            enc_res.byte_count = enc_total;
            enc_res.status     = STAT_OK;
            enc_res.last       = enc_last;
        end
    end

    // prefix decode or payload accumulate, one byte per word
    always_comb begin
        seen_inc   = r_seen + 4'd1;
        acc_merged = r_acc;
        if (r_seen < 4'd8) begin
            acc_merged = r_acc | (64'(r_item.in_byte) << {r_seen[2:0], 3'b000});
        end

        dec_has_res = 1'b0;
        dec_res     = '0;
        n_expected  = r_expected;
        n_seen      = r_seen;
        n_acc       = r_acc;

        if (r_expected == 4'd0) begin
            if (r_item.in_byte < PFX_16) begin
                // single-byte value
                dec_has_res        = 1'b1;
                dec_res.kind       = KIND_VALUE;
                dec_res.value_out  = 64'(r_item.in_byte);
                dec_res.byte_count = LEN_1;
                dec_res.status     = STAT_OK;
                dec_res.last       = 1'b1;
            end else if (r_item.buffer_end) begin
                // prefix alone at buffer end
                dec_has_res    = 1'b1;
                dec_res.kind   = KIND_ERROR;
                dec_res.status = STAT_SHORT;
                dec_res.last   = 1'b1;
            end else begin
                n_expected = (r_item.in_byte == PFX_16) ? PAY_16 :
                             (r_item.in_byte == PFX_32) ? PAY_32 : PAY_64;
                n_seen     = 4'd0;
                n_acc      = '0;
            end
        end else if (seen_inc >= r_expected) begin
            // payload complete
            dec_has_res        = 1'b1;
            dec_res.kind       = KIND_VALUE;
            dec_res.value_out  = acc_merged;
            dec_res.byte_count = r_expected + 4'd1;
            dec_res.status     = STAT_OK;
            dec_res.last       = 1'b1;
            n_expected         = 4'd0;
            n_seen             = 4'd0;
            n_acc              = '0;
        end else if (r_item.buffer_end) begin
            // buffer ran out mid payload
            dec_has_res    = 1'b1;
            dec_res.kind   = KIND_ERROR;
            dec_res.status = STAT_SHORT;
            dec_res.last   = 1'b1;
            n_expected     = 4'd0;
            n_seen         = 4'd0;
            n_acc          = '0;
        end else begin
            n_seen = seen_inc;
            n_acc  = acc_merged;
        end
    end

    // stage advances when its result can land or it has none
    always_comb begin
        has_res   = (r_item.mode == MODE_ENC) ? 1'b1 : dec_has_res;
        res       = (r_item.mode == MODE_ENC) ? enc_res : dec_res;
        out_free  = !r_res_vld || o_res.ready;
        step      = r_item_vld && (!has_res || out_free);
        item_done = step && ((r_item.mode == MODE_DEC) || !enc_fits || enc_last);
        n_idx     = item_done ? 4'd0 : (step ? r_idx + 4'd1 : r_idx);
    end

    assign i_item.ready  = !r_item_vld || item_done;
    assign o_res.valid   = r_res_vld;
    assign o_res.payload = r_res;

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_idx      <= 4'd0;
        end else begin
            r_idx <= n_idx;
            if (i_item.valid && i_item.ready) begin
                r_item_vld <= 1'b1;
            end else if (item_done) begin
                r_item_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= i_item.payload;
        end
    end

    // decoder state moves only on decode words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 4'd0;
            r_seen     <= 4'd0;
            r_acc      <= '0;
        end else if (step && (r_item.mode == MODE_DEC)) begin
            r_expected <= n_expected;
            r_seen     <= n_seen;
            r_acc      <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (step && has_res) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_res) begin
            r_res <= res;
        end
    end

    // idle decoder holds no partial payload
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected == 4'd0) |-> (r_seen == 4'd0 && r_acc == 64'd0))
        else $error("decoder idle with partial payload");

    // awaited payload length is a legal one and not yet reached
    a_expected_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected != 4'd0) |-> ((r_expected == PAY_16 || r_expected == PAY_32 ||
                                   r_expected == PAY_64) && r_seen < r_expected))
        else $error("decoder payload count out of range");

    // encode byte index never passes the longest encoding
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < LEN_9)
        else $error("encode byte index out of range");

    // an error closes its run and carries no length
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.kind == KIND_ERROR) |-> (r_res.last && r_res.byte_count == 4'd0))
        else $error("error word malformed");

endmodule

// File: tb/varint_compact_size_codec_unit_tb.sv
`timescale 1ns / 1ps

module varint_compact_size_codec_unit_tb;
    import vcsc_pkg::*;

    localparam int N_RANDOM_TOTAL = 170;     // directed plus random input words
    localparam int TAIL_CYCLES    = 20;      // drain after the last result
    localparam int HOLD_CYCLES    = 80;      // long receiver hold-off
    localparam int LIMIT_NS       = 2_500_000;

    logic i_clk;
    logic i_rst_n;

    vcsc_in_if  u_in_ch ();
    vcsc_out_if u_out_ch ();

    varint_compact_size_codec_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (u_in_ch),
        .o_res   (u_out_ch)
    );

    // words waiting to be offered, results the codec still owes us
    t_in_word  in_words_todo[$];
    t_out_word out_words_due[$];

    // decoder state as the predictor sees it
    logic [3:0]  dec_need;
    logic [3:0]  dec_seen;
    logic [63:0] dec_acc;

    int   fail_count  = 0;
    int   words_taken = 0;
    int   send_gap    = 0;
    int   recv_stall  = 0;
    logic rx_hold     = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // reset once, inputs known from time zero
    initial begin
        i_rst_n          = 1'b0;
        u_in_ch.valid    = 1'b0;
        u_in_ch.payload  = '0;
        u_out_ch.ready   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // mostly short idles, now and then a long one, often none at all
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_out_word make_out(t_kind k, logic [7:0] b, logic [63:0] v,
                                           logic [3:0] cnt, t_status st, logic lst);
        t_out_word o;
        o.kind       = k;
        o.out_byte   = b;
        o.value_out  = v;
        o.byte_count = cnt;
        o.status     = st;
        o.last       = lst;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    // expected results of one accepted input word
    task automatic predict_codec_step(input t_in_word w);
        logic [3:0] pay;
        logic [3:0] len;
        logic [7:0] pfx;
        if (w.mode == MODE_ENC) begin
            // size class picks the prefix and the payload length
            if (w.value_in < {56'h0, PFX_16}) begin
                pay = 4'd0;
                len = LEN_1;
                pfx = w.value_in[7:0];
            end else if (w.value_in <= MAX_16) begin
                pay = PAY_16;
                len = LEN_3;
                pfx = PFX_16;
            end else if (w.value_in <= MAX_32) begin
                pay = PAY_32;
                len = LEN_5;
                pfx = PFX_32;
            end else begin
                pay = PAY_64;
                len = LEN_9;
                pfx = PFX_64;
            end
            if (w.space_left < len) begin
                // no room: a single error, nothing emitted
                out_words_due.push_back(make_out(KIND_ERROR, 8'h00, 64'h0, 4'd0,
                                                 STAT_SMALL, 1'b1));
            end else begin
                out_words_due.push_back(make_out(KIND_BYTE, pfx, 64'h0, len, STAT_OK,
                                                 len == LEN_1));
                for (int i = 0; i < int'(pay); i++)
                    out_words_due.push_back(make_out(KIND_BYTE, w.value_in[8*i +: 8],
                                                     64'h0, len, STAT_OK,
                                                     (i + 1) == int'(pay)));
            end
        end else if (dec_need == 4'd0) begin
            // awaiting a prefix
            if (w.in_byte < PFX_16) begin
                out_words_due.push_back(make_out(KIND_VALUE, 8'h00, {56'h0, w.in_byte},
                                                 LEN_1, STAT_OK, 1'b1));
            end else begin
                dec_need = (w.in_byte == PFX_16) ? PAY_16 :
                           (w.in_byte == PFX_32) ? PAY_32 : PAY_64;
                dec_seen = 4'd0;
                dec_acc  = 64'h0;
                if (w.buffer_end) begin
                    // buffer ended right on the prefix
                    dec_need = 4'd0;
                    out_words_due.push_back(make_out(KIND_ERROR, 8'h00, 64'h0, 4'd0,
                                                     STAT_SHORT, 1'b1));
                end
            end
        end else begin
            // payload bytes arrive little-endian
            dec_acc  = dec_acc | (64'(w.in_byte) << {dec_seen[2:0], 3'b000});
            dec_seen = dec_seen + 4'd1;
            if (dec_seen >= dec_need) begin
                out_words_due.push_back(make_out(KIND_VALUE, 8'h00, dec_acc,
                                                 dec_need + 4'd1, STAT_OK, 1'b1));
                dec_need = 4'd0;
                dec_seen = 4'd0;
                dec_acc  = 64'h0;
            end else if (w.buffer_end) begin
                // buffer ran out mid payload
                dec_need = 4'd0;
                dec_seen = 4'd0;
                dec_acc  = 64'h0;
                out_words_due.push_back(make_out(KIND_ERROR, 8'h00, 64'h0, 4'd0,
                                                 STAT_SHORT, 1'b1));
            end
        end
    endtask

    // unused fields get random content so every input bit toggles
    task automatic queue_encode(input logic [63:0] v, input logic [3:0] sp);
        t_in_word w;
        w.mode       = MODE_ENC;
        w.value_in   = v;
        w.space_left = sp;
        w.in_byte    = 8'($urandom);
        w.buffer_end = 1'($urandom);
        in_words_todo.push_back(w);
    endtask

    task automatic queue_decode(input logic [7:0] b, input logic e);
        t_in_word w;
        w.mode       = MODE_DEC;
        w.value_in   = {$urandom, $urandom};
        w.space_left = 4'($urandom);
        w.in_byte    = b;
        w.buffer_end = e;
        in_words_todo.push_back(w);
    endtask

    // sender: one word in flight, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_in_ch.valid <= 1'b0;
            dec_need = 4'd0;
            dec_seen = 4'd0;
            dec_acc  = 64'h0;
        end else begin
            if (u_in_ch.valid && u_in_ch.ready) begin
                predict_codec_step(u_in_ch.payload);
                words_taken++;
            end
            // only move on once the offered word is gone
            if (!u_in_ch.valid || u_in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    u_in_ch.valid <= 1'b0;
                end else if (in_words_todo.size() > 0) begin
                    u_in_ch.payload <= in_words_todo.pop_front();
                    u_in_ch.valid   <= 1'b1;
                    send_gap = pick_idle_len();
                end else begin
                    u_in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: field-by-field check against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            u_out_ch.ready <= 1'b0;
        end else begin
            if (u_out_ch.valid && u_out_ch.ready) begin
                if (out_words_due.size() == 0) begin
                    report_mismatch("unexpected word, kind",
                                    64'(u_out_ch.payload.kind), 64'h0);
                end else begin
                    want = out_words_due.pop_front();
                    if (u_out_ch.payload.kind !== want.kind)
                        report_mismatch("kind", 64'(u_out_ch.payload.kind),
                                        64'(want.kind));
                    if (u_out_ch.payload.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(u_out_ch.payload.out_byte),
                                        64'(want.out_byte));
                    if (u_out_ch.payload.value_out !== want.value_out)
                        report_mismatch("value_out", u_out_ch.payload.value_out,
                                        want.value_out);
                    if (u_out_ch.payload.byte_count !== want.byte_count)
                        report_mismatch("byte_count", 64'(u_out_ch.payload.byte_count),
                                        64'(want.byte_count));
                    if (u_out_ch.payload.status !== want.status)
                        report_mismatch("status", 64'(u_out_ch.payload.status),
                                        64'(want.status));
                    if (u_out_ch.payload.last !== want.last)
                        report_mismatch("last", 64'(u_out_ch.payload.last),
                                        64'(want.last));
                end
            end
            // stall decision for the next cycle
            if (rx_hold) begin
                u_out_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                u_out_ch.ready <= 1'b0;
            end else begin
                recv_stall = pick_idle_len();
                u_out_ch.ready <= (recv_stall == 0);
                if (recv_stall > 0)
                    recv_stall--;
            end
        end
    end

    // long hold-offs so the codec backs up and stalls the sender
    initial begin : long_hold
        for (int k = 0; k < 2; k++) begin
            while (words_taken < 40 + 70 * k)
                @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // stimulus, then drain and verdict
    initial begin : stim_and_verdict
        int          cls;
        int          pick;
        int          n_pay;
        logic [63:0] v;
        logic [31:0] r;
        logic [3:0]  need;

        // encode extremes of every size class, with and without room
        queue_encode(64'h0, 4'd1);
        queue_encode(64'hFC, 4'd15);
        queue_encode(64'hFD, 4'd3);
        queue_encode(64'hFFFF, 4'd2);              // too small
        queue_encode(64'h1_0000, 4'd5);
        queue_encode(64'hFFFF_FFFF, 4'd4);         // too small
        queue_encode(64'h1_0000_0000, 4'd9);
        queue_encode(64'hFFFF_FFFF_FFFF_FFFF, 4'd8); // too small
        queue_encode(64'h0, 4'd0);                 // too small even for one byte
        queue_encode(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);

        // decode: single byte values, one with buffer end
        queue_decode(8'h00, 1'b0);
        queue_decode(8'hFC, 1'b1);
        // 16-bit value completing on the buffer end
        queue_decode(PFX_16, 1'b0);
        queue_decode(8'h34, 1'b0);
        queue_decode(8'h12, 1'b1);
        // buffer ends on the prefix itself
        queue_decode(PFX_32, 1'b1);
        // 64-bit value cut short, with an encode slipped in mid decode
        queue_decode(PFX_64, 1'b0);
        queue_decode(8'hAA, 1'b0);
        queue_encode(64'h1234, 4'd3);
        queue_decode(8'hBB, 1'b1);
        // completed value without buffer end, next byte starts a new value
        queue_decode(PFX_16, 1'b0);
        queue_decode(8'hFF, 1'b0);
        queue_decode(8'hFF, 1'b0);
        queue_decode(8'h05, 1'b0);

        // random part: mostly well-formed encode and decode words with random content
        while (in_words_todo.size() < N_RANDOM_TOTAL) begin
            pick = $urandom_range(0, 99);
            cls  = $urandom_range(0, 3);
            if (pick < 35) begin
                case (cls)
                    0: begin
                        v    = 64'($urandom_range(0, 252));
                        need = LEN_1;
                    end
                    1: begin
                        v    = 64'($urandom_range(253, 65535));
                        need = LEN_3;
                    end
                    2: begin
                        r = $urandom;
                        if (r < 32'h1_0000)
                            r = r | 32'h1_0000;
                        v    = {32'h0, r};
                        need = LEN_5;
                    end
                    default: begin
                        r = $urandom;
                        if (r == 32'h0)
                            r = 32'h1;
                        v    = {r, $urandom};
                        need = LEN_9;
                    end
                endcase
                if ($urandom_range(0, 4) == 0)
                    queue_encode(v, 4'($urandom_range(0, 15)));
                else
                    queue_encode(v, 4'($urandom_range(32'(need), 15)));
            end else if (pick < 80) begin
                // well-formed decode sequence, buffer end on the last byte or not
                if (cls == 0) begin
                    queue_decode(8'($urandom_range(0, 252)), 1'($urandom));
                end else begin
                    n_pay = (cls == 1) ? int'(PAY_16) : (cls == 2) ? int'(PAY_32) :
                                                                     int'(PAY_64);
                    queue_decode((cls == 1) ? PFX_16 : (cls == 2) ? PFX_32 : PFX_64, 1'b0);
                    for (int j = 0; j < n_pay; j++)
                        queue_decode(8'($urandom),
                                     (j == n_pay - 1) ? 1'($urandom) : 1'b0);
                end
            end else if (pick < 90) begin
                // truncated sequence: buffer ends before the payload is complete
                if (cls == 0)
                    cls = 1;
                n_pay = (cls == 1) ? int'(PAY_16) : (cls == 2) ? int'(PAY_32) :
                                                                 int'(PAY_64);
                n_pay = $urandom_range(0, n_pay - 1);
                queue_decode((cls == 1) ? PFX_16 : (cls == 2) ? PFX_32 : PFX_64,
                             n_pay == 0);
                for (int j = 0; j < n_pay; j++)
                    queue_decode(8'($urandom), j == n_pay - 1);
            end else begin
                // noise
                queue_decode(8'($urandom), 1'($urandom));
            end
        end

        // wait until every word is taken and every result has come back
        while (!(in_words_todo.size() == 0 && !u_in_ch.valid && out_words_due.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("varint_compact_size_codec_unit_tb: done, clean");
        else
            $display("varint_compact_size_codec_unit_tb: done, errors");
        $finish;
    end

    // hard stop if the codec hangs
    initial begin : run_limit
        #(LIMIT_NS);
        $display("[%0t] timeout, %0d results still due, %0d words unsent",
                 $time, out_words_due.size(), in_words_todo.size());
        $display("varint_compact_size_codec_unit_tb: done, errors");
        $finish;
    end

endmodule
